// ===== sv/lvpd_pkg.sv =====
// ---------------------------------------------------------------------------
// lvpd_pkg: shared types and constants for the latency vote deframer
// Beat types, register indexes, framing constants.
// ---------------------------------------------------------------------------
`default_nettype none

package lvpd_pkg;

    localparam int unsigned LAT_W       = 16;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [LAT_W-1:0]  MISS_THRESHOLD_RST = 16'd154;
    localparam logic [LAT_W-1:0]  NOISE_LIMIT_RST    = 16'd1000;
    localparam logic [CNT_W-1:0]  COUNT_MAX          = 16'hFFFF;
    localparam logic [2:0]        PREAMBLE_FLIPS     = 3'd4;
    localparam logic [2:0]        LAST_BIT_POS       = 3'd7;
    localparam logic [BYTE_W-1:0] MAX_BYTES          = 8'd128;

    localparam logic [CFG_IDX_W-1:0] REG_MISS_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT    = 2'd1;

    typedef struct packed {
        logic [LAT_W-1:0] latency;
        logic             window_end;
    } lvpd_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              message_end;
        logic              byte_valid;
    } lvpd_out_t;

    typedef struct packed {
        logic is_hit;
        logic is_miss;
        logic window_end;
    } lvpd_cls_t;

    typedef enum logic [1:0] {
        MODE_HUNT    = 2'b01,
        MODE_PAYLOAD = 2'b10
    } lvpd_mode_t;

endpackage

`default_nettype wire

// ===== sv/lvpd_front.sv =====
// ---------------------------------------------------------------------------
// lvpd_front: sample intake and classification
// Holds the threshold registers and tags each sample as hit, miss or noise.
// ---------------------------------------------------------------------------
`default_nettype none

module lvpd_front
    import lvpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LAT_W-1:0]     cfg_data,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire lvpd_in_t             sample,
    output logic                      push,
    output lvpd_cls_t                 push_data,
    input  wire logic                 queue_full
);

    logic [LAT_W-1:0] miss_threshold_reg;
    logic [LAT_W-1:0] noise_limit_reg;
    logic             front_valid_reg;
    logic             front_valid_next;
    lvpd_cls_t        cls_reg;
    lvpd_cls_t        cls_next;
    logic             accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_threshold_reg <= MISS_THRESHOLD_RST;
            noise_limit_reg    <= NOISE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MISS_THRESHOLD: miss_threshold_reg <= cfg_data;
                REG_NOISE_LIMIT:    noise_limit_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign sample_stall = front_valid_reg && queue_full;
    assign accept       = sample_valid && !sample_stall;
    assign push         = front_valid_reg && !queue_full;
    assign push_data    = cls_reg;

    always_comb
    begin
        cls_next.is_hit     = sample.latency < miss_threshold_reg;
        cls_next.is_miss    = !cls_next.is_hit && (sample.latency < noise_limit_reg);
        cls_next.window_end = sample.window_end;
        front_valid_next    = accept || (front_valid_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cls_reg <= cls_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lvpd_queue.sv =====
// ---------------------------------------------------------------------------
// lvpd_queue: short FIFO between classifier and decoder
// Lets either side stall without holding up the other.
// ---------------------------------------------------------------------------
`default_nettype none

module lvpd_queue
    import lvpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire lvpd_cls_t push_data,
    output logic           full,
    input  wire logic      pop,
    output lvpd_cls_t      pop_data,
    output logic           not_empty
);

    lvpd_cls_t            entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;

    assign full      = (count_reg == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ===== sv/lvpd_back.sv =====
// ---------------------------------------------------------------------------
// lvpd_back: vote counting, preamble hunt and byte framing
// Decides one bit per window, finds the preamble, packs bytes, holds result.
// ---------------------------------------------------------------------------
`default_nettype none

module lvpd_back
    import lvpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      not_empty,
    input  wire lvpd_cls_t pop_data,
    output logic           pop,
    output logic           result_valid,
    input  wire logic      result_stall,
    output lvpd_out_t      result
);

    logic [CNT_W-1:0]  hit_reg,   hit_next;
    logic [CNT_W-1:0]  miss_reg,  miss_next;
    logic [CNT_W-1:0]  hit_sum,   miss_sum;
    logic [2:0]        flips_reg, flips_next;
    logic              prev_reg,  prev_next;
    lvpd_mode_t        mode_reg,  mode_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [2:0]        pos_reg,   pos_next;
    logic [BYTE_W-1:0] bytes_reg, bytes_next;
    logic              res_valid_reg, res_valid_next;
    lvpd_out_t         res_reg,   res_next;
    logic              emit;
    logic              bit_val;
    logic [BYTE_W-1:0] shifted;
    logic [BYTE_W-1:0] bytes_inc;

    assign pop          = not_empty && (!res_valid_reg || !result_stall);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        hit_sum   = (pop_data.is_hit && hit_reg != COUNT_MAX) ? hit_reg + 1'b1 : hit_reg;
        miss_sum  = (pop_data.is_miss && miss_reg != COUNT_MAX) ? miss_reg + 1'b1 : miss_reg;
        bit_val   = hit_sum > miss_sum;
        shifted   = {shift_reg[BYTE_W-2:0], bit_val};
        bytes_inc = bytes_reg + 1'b1;

        hit_next   = hit_reg;
        miss_next  = miss_reg;
        flips_next = flips_reg;
        prev_next  = prev_reg;
        mode_next  = mode_reg;
        shift_next = shift_reg;
        pos_next   = pos_reg;
        bytes_next = bytes_reg;
        emit       = 1'b0;
        res_next   = res_reg;

        if (pop)
        begin
            hit_next  = hit_sum;
            miss_next = miss_sum;
            if (pop_data.window_end)
            begin
                hit_next  = '0;
                miss_next = '0;
                case (mode_reg)
                    MODE_HUNT:
                    begin
                        if (flips_reg == '0 && bit_val && prev_reg)
                        begin
                            mode_next  = MODE_PAYLOAD;
                            shift_next = '0;
                            pos_next   = '0;
                            bytes_next = '0;
                        end
                        else if (flips_reg != '0 && bit_val != prev_reg)
                        begin
                            flips_next = flips_reg - 1'b1;
                        end
                        else if (bit_val == prev_reg)
                        begin
                            flips_next = PREAMBLE_FLIPS;
                        end
                        prev_next = bit_val;
                    end
                    MODE_PAYLOAD:
                    begin
                        if (pos_reg != LAST_BIT_POS)
                        begin
                            shift_next = shifted;
                            pos_next   = pos_reg + 1'b1;
                        end
                        else
                        begin
                            emit     = 1'b1;
                            pos_next = '0;
                            if (shifted == '0 || bytes_inc >= MAX_BYTES)
                            begin
                                res_next.data_byte   = shifted;
                                res_next.message_end = 1'b1;
                                res_next.byte_valid  = (shifted != '0);
                                flips_next = PREAMBLE_FLIPS;
                                prev_next  = 1'b1;
                                mode_next  = MODE_HUNT;
                                shift_next = '0;
                                bytes_next = '0;
                            end
                            else
                            begin
                                res_next.data_byte   = shifted;
                                res_next.message_end = 1'b0;
                                res_next.byte_valid  = 1'b1;
                                shift_next = '0;
                                bytes_next = bytes_inc;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_HUNT;
                    end
                endcase
            end
        end

        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= '0;
            miss_reg      <= '0;
            flips_reg     <= PREAMBLE_FLIPS;
            prev_reg      <= 1'b1;
            mode_reg      <= MODE_HUNT;
            shift_reg     <= '0;
            pos_reg       <= '0;
            bytes_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            hit_reg       <= hit_next;
            miss_reg      <= miss_next;
            flips_reg     <= flips_next;
            prev_reg      <= prev_next;
            mode_reg      <= mode_next;
            shift_reg     <= shift_next;
            pos_reg       <= pos_next;
            bytes_reg     <= bytes_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTH
    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HUNT) |-> (pos_reg == '0 && shift_reg == '0 && bytes_reg == '0))
        else $error("payload state left over while hunting");

    a_byte_limit: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg < MAX_BYTES)
        else $error("byte count reached limit without ending message");
`endif

endmodule

`default_nettype wire

// ===== sv/latency_vote_preamble_deframer.sv =====
// ---------------------------------------------------------------------------
// latency_vote_preamble_deframer: majority-vote bit receiver with framing
// Turns latency samples into voted bits, hunts a preamble, emits payload bytes.
// ---------------------------------------------------------------------------
// One sample beat is taken every clock while sample_stall is low. A sample
// passes the classifier register, a four-entry FIFO and the decoder before
// its result beat, if any, appears in the output register. A stalled result
// holds the decoder; FIFO and classifier register then absorb up to five more
// samples before sample_stall rises. The user writes threshold registers via
// cfg_we / cfg_index / cfg_data while no sample is in flight; not enforced.
`default_nettype none

module latency_vote_preamble_deframer
    import lvpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LAT_W-1:0]     cfg_data,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire lvpd_in_t             sample,
    output logic                      result_valid,
    input  wire logic                 result_stall,
    output lvpd_out_t                 result
);

    logic      push;
    lvpd_cls_t push_data;
    logic      queue_full;
    logic      pop;
    lvpd_cls_t pop_data;
    logic      not_empty;

    lvpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_data    (push_data),
        .queue_full   (queue_full)
    );

    lvpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    lvpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .not_empty    (not_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
